FILE: hdl/hcrd_pkg.sv
// ----------------------------------------------------------------------------
// hcrd_pkg
// Types, widths and register indexes shared by the Hill row decrypt core.
// ----------------------------------------------------------------------------
package hcrd_pkg;

  localparam int ADJ_W       = 17;
  localparam int DET_W       = 27;
  localparam int DABS_W      = 26;
  localparam int D31_W       = 31;
  localparam int PRINT_FLOOR = 31;
  localparam int ROW_W       = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] CFG_KEY_SIZE = 2'd0;
  localparam logic [1:0] CFG_KEY_ROW0 = 2'd1;
  localparam logic [1:0] CFG_KEY_ROW1 = 2'd2;
  localparam logic [1:0] CFG_KEY_ROW2 = 2'd3;

  localparam logic [1:0] KEY_SIZE_1 = 2'd1;
  localparam logic [1:0] KEY_SIZE_2 = 2'd2;
  localparam logic [1:0] KEY_SIZE_3 = 2'd3;

  typedef struct packed {
    logic [1:0]        size;
    logic              dneg;
    logic [DABS_W-1:0] dabs;
    logic [D31_W-1:0]  d31;
  } hcrd_key_t;

  function automatic logic signed [ADJ_W-1:0] cofactor(
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] c, input logic [7:0] d);
    return ADJ_W'(a) * ADJ_W'(b) - ADJ_W'(c) * ADJ_W'(d);
  endfunction

endpackage

FILE: hdl/hcrd_lane.sv
// ----------------------------------------------------------------------------
// hcrd_lane
// One output column: dot product, sign normalize, pipelined rounded divide.
// ----------------------------------------------------------------------------
module hcrd_lane import hcrd_pkg::*; #(
  parameter int VALUE_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [VALUE_BITS-1:0]         v_i [3],
  input  logic signed [ADJ_W-1:0]       adj_i [3],
  input  hcrd_key_t                     key_i,
  output logic [7:0]                    char_o,
  output logic                          stop_o
);

  localparam int PROD_W = VALUE_BITS + ADJ_W + 1;
  localparam int NUM_W  = PROD_W + 2;
  localparam int AW     = NUM_W;
  localparam int D_W    = DABS_W + 1;
  localparam int RW     = D_W + 1;

  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [NUM_W-1:0]  num_q;
  logic signed [NUM_W-1:0]  numn;
  logic signed [NUM_W-1:0]  mag;
  logic                     neg;
  logic                     stop;
  logic [D_W-1:0]           dv;

  logic [AW-1:0] a_q    [AW+1];
  logic [RW-1:0] rem_q  [AW+1];
  logic [7:0]    quo_q  [AW+1];
  logic          neg_q  [AW+1];
  logic          stop_q [AW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= $signed({1'b0, v_i[i]}) * adj_i[i];
      end
      num_q <= NUM_W'(prod_q[0]) + NUM_W'(prod_q[1]) + NUM_W'(prod_q[2]);
    end
  end

  always_comb begin
    numn = key_i.dneg ? -num_q : num_q;
    neg  = numn < 0;
    mag  = neg ? -numn : numn;
    stop = 1'b0;
    if (key_i.size == KEY_SIZE_3) begin
      stop = numn <= 0;
    end else if (key_i.size == KEY_SIZE_2) begin
      stop = numn <= $signed(NUM_W'(key_i.d31));
    end
    dv = {key_i.dabs, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]    <= {mag[NUM_W-2:0], 1'b0} + AW'(key_i.dabs);
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg;
      stop_q[0] <= stop;
    end
  end

  for (genvar k = 0; k < AW; k++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      trial = {rem_q[k][RW-2:0], a_q[k][AW-1]};
      ge    = trial >= RW'(dv);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial - RW'(dv) : trial;
        a_q[k+1]    <= {a_q[k][AW-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][6:0], ge};
        neg_q[k+1]  <= neg_q[k];
        stop_q[k+1] <= stop_q[k];
      end
    end
  end

  assign char_o = neg_q[AW] ? 8'(-quo_q[AW]) : quo_q[AW];
  assign stop_o = stop_q[AW];

endmodule

FILE: hdl/hill_cipher_row_decrypt_core.sv
// Throughput: one row per cycle unless the output stalls; set by the per-bit restoring divide pipeline.
// A stalled output holds the whole pipeline.
// Reset: key order 3, key rows 0, pipeline empty; no clearing pass.
// ----------------------------------------------------------------------------
// hill_cipher_row_decrypt_core
// Hill cipher row decrypt: three column lanes and a merge into one result.
// ----------------------------------------------------------------------------
module hill_cipher_row_decrypt_core import hcrd_pkg::*; #(
  parameter int VALUE_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_addr_i,
  input  logic [ROW_W-1:0]                       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // value0, value1, value2, zero pad
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // char0, char1, char2, char_count, zero pad
  output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
  // key_error
  output logic                                   m_axis_tuser
);

  localparam int LANE_LAT = VALUE_BITS + ADJ_W + 6;
  localparam int PIPE_LEN = LANE_LAT + 2;

  logic [1:0]       size_q;
  logic [ROW_W-1:0] row_q [3];
  logic [7:0]       m [3][3];

  logic signed [ADJ_W-1:0] adj_d [3][3];
  logic signed [ADJ_W-1:0] adj_q [3][3];
  logic [1:0]              size1_q;
  logic signed [DET_W-1:0] det_q;
  logic [1:0]              size2_q;
  hcrd_key_t               key_q;
  logic                    err_q;

  logic                  en;
  logic [PIPE_LEN-1:0]   vld_q;
  logic [VALUE_BITS-1:0] v1_q [3];
  logic [VALUE_BITS-1:0] v2_q [3];
  logic [7:0]            lane_char [3];
  logic                  lane_stop [3];

  logic [2:0]            keep;
  logic [1:0]            cnt;
  logic                  out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                  out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= KEY_SIZE_3;
      row_q  <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_KEY_SIZE: size_q   <= cfg_wdata_i[1:0];
        CFG_KEY_ROW0: row_q[0] <= cfg_wdata_i;
        CFG_KEY_ROW1: row_q[1] <= cfg_wdata_i;
        CFG_KEY_ROW2: row_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r][c] = row_q[r][8*c +: 8];
      end
    end
  end

  always_comb begin
    adj_d = '{default: '0};
    unique case (size_q)
      KEY_SIZE_1: adj_d[0][0] = ADJ_W'(1);
      KEY_SIZE_2: begin
        adj_d[0][0] = ADJ_W'(m[1][1]);
        adj_d[0][1] = -ADJ_W'(m[0][1]);
        adj_d[1][0] = -ADJ_W'(m[1][0]);
        adj_d[1][1] = ADJ_W'(m[0][0]);
      end
      KEY_SIZE_3: begin
        adj_d[0][0] = cofactor(m[1][1], m[2][2], m[2][1], m[1][2]);
        adj_d[0][1] = cofactor(m[0][2], m[2][1], m[2][2], m[0][1]);
        adj_d[0][2] = cofactor(m[0][1], m[1][2], m[1][1], m[0][2]);
        adj_d[1][0] = cofactor(m[1][2], m[2][0], m[2][2], m[1][0]);
        adj_d[1][1] = cofactor(m[0][0], m[2][2], m[2][0], m[0][2]);
        adj_d[1][2] = cofactor(m[0][2], m[1][0], m[1][2], m[0][0]);
        adj_d[2][0] = cofactor(m[1][0], m[2][1], m[2][0], m[1][1]);
        adj_d[2][1] = cofactor(m[0][1], m[2][0], m[2][1], m[0][0]);
        adj_d[2][2] = cofactor(m[0][0], m[1][1], m[1][0], m[0][1]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    adj_q   <= adj_d;
    size1_q <= size_q;
  end

  always_ff @(posedge clk_i) begin
    size2_q <= size1_q;
    det_q   <= DET_W'($signed({1'b0, m[0][0]})) * DET_W'(adj_q[0][0])
             + DET_W'($signed({1'b0, m[0][1]})) * DET_W'(adj_q[1][0])
             + DET_W'($signed({1'b0, m[0][2]})) * DET_W'(adj_q[2][0]);
    key_q.size <= size2_q;
    key_q.dneg <= det_q < 0;
    key_q.dabs <= DABS_W'(det_q < 0 ? -det_q : det_q);
    key_q.d31  <= (D31_W'(det_q < 0 ? -det_q : det_q) << 5)
                - D31_W'(det_q < 0 ? -det_q : det_q);
    err_q      <= det_q == 0;
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= s_axis_tdata[i*VALUE_BITS +: VALUE_BITS];
      end
      v2_q <= v1_q;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic signed [ADJ_W-1:0] col [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        col[i] = adj_q[i][j];
      end
    end
    hcrd_lane #(
      .VALUE_BITS(VALUE_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .v_i    (v2_q),
      .adj_i  (col),
      .key_i  (key_q),
      .char_o (lane_char[j]),
      .stop_o (lane_stop[j])
    );
  end

  always_comb begin
    keep[0] = !err_q && key_q.size != 2'd0 && !lane_stop[0];
    keep[1] = keep[0] && key_q.size != KEY_SIZE_1 && !lane_stop[1];
    keep[2] = keep[1] && key_q.size == KEY_SIZE_3 && !lane_stop[2];
    cnt     = 2'(keep[0]) + 2'(keep[1]) + 2'(keep[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {6'd0, cnt,
                     keep[2] ? lane_char[2] : 8'd0,
                     keep[1] ? lane_char[1] : 8'd0,
                     keep[0] ? lane_char[0] : 8'd0};
      out_err_q  <= err_q || key_q.size == 2'd0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

`ifndef NO_ASSERTIONS
  a_err_no_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:24] == 2'd0)
    else $error("key error with characters");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25:24] == 2'd0 |-> m_axis_tdata[7:0] == 8'd0)
    else $error("char0 set past count");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(out_data_q) && $stable(vld_q))
    else $error("pipeline moved under stall");
`endif

endmodule
